// ----- hdl/vgsb_pkg.sv -----
// vgsb_pkg: shared constants and types for the voxel grid share binner
// no dependencies
package vgsb_pkg;
  localparam int GRID_DEF    = 4;
  localparam int COORD_W     = 24;
  localparam int SHARE_W     = 17;
  localparam int CNT_W       = 32;
  localparam int SUM_W       = 48;
  localparam int RATIO_W     = 17;
  localparam int IDX_W       = 6;
  localparam int DIV_W       = 48;
  localparam logic [SHARE_W-1:0] SHARE_ONE = 17'd65536;
  localparam logic [CNT_W-1:0]   COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_X = 3'd3;
  localparam logic [2:0] REG_MAX_Y = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;
endpackage

// ----- hdl/vgsb_divider.sv -----
// vgsb_divider: shared restoring divider, one quotient bit per cycle
// depends on vgsb_pkg
module vgsb_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  vgsb_pkg::div_req_t req,
  output vgsb_pkg::div_rsp_t rsp
);
  localparam int W = vgsb_pkg::DIV_W;

  logic         busy_r, busy_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] quo_r, quo_nxt;
  logic [W-1:0] dsr_r, dsr_nxt;
  logic         done_r, done_nxt;
  logic [W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[W-1]} - {1'b0, dsr_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(W - 1);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
endmodule

// ----- hdl/voxel_grid_share_binner_unit.sv -----
// voxel_grid_share_binner_unit: top level, sequencer, config port and voxel stores
// depends on vgsb_pkg and vgsb_divider
//
// Each point is accepted, then its three axis bin divisions run one after
// the other on a shared 48-step restoring divider (a start, then a wait for
// the quotient), then a read-modify-write of the voxel's count and sum
// memories. An axis that is empty or inverted, or whose coordinate lies at or
// below the box, skips its division and gets bin 0. A point with final_point
// set then starts the readout: for each of GRID^3 voxels the sum is divided by
// the count on the same divider, and each result beat is held until out_ready
// takes it. The voxel entry is cleared as it is read, so no separate clearing
// pass is needed. After reset a clearing pass zeroes all 64 entries of both
// stores before the first point is taken; config writes are taken throughout.
// in_ready is low during the clearing pass and while a point or readout is in
// progress.
module voxel_grid_share_binner_unit #(
  parameter int GRID = vgsb_pkg::GRID_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [vgsb_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [vgsb_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [vgsb_pkg::COORD_W-1:0] in_pos_z,
  input  logic [vgsb_pkg::SHARE_W-1:0]      in_element_share,
  input  logic                              in_final_point,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vgsb_pkg::IDX_W-1:0]        out_voxel_index,
  output logic [vgsb_pkg::RATIO_W-1:0]      out_voxel_ratio,
  output logic                              out_last_voxel,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [4:0]                        cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  localparam int CW    = vgsb_pkg::COORD_W;
  localparam int DW    = vgsb_pkg::DIV_W;
  localparam int IW    = vgsb_pkg::IDX_W;
  localparam int TOTAL = GRID * GRID * GRID;
  localparam int DEPTH = 1 << IW;
  localparam int BW    = $clog2(GRID);

  // sequencer states
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_AXIS   = 4'd2;
  localparam logic [3:0] ST_AWAIT  = 4'd3;
  localparam logic [3:0] ST_RD     = 4'd4;
  localparam logic [3:0] ST_WR     = 4'd5;
  localparam logic [3:0] ST_OUTRD  = 4'd6;
  localparam logic [3:0] ST_OUTDIV = 4'd7;
  localparam logic [3:0] ST_OWAIT  = 4'd8;
  localparam logic [3:0] ST_OUT    = 4'd9;

  // config registers
  logic [CW-1:0] lo_r [3];
  logic [CW-1:0] hi_r [3];

  logic       wr_en;
  logic [2:0] wr_sel;
  assign cfg_pready = 1'b1;
  assign wr_en  = cfg_psel && cfg_penable && cfg_pwrite;
  assign wr_sel = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= '0;
        hi_r[i] <= 24'd65536;
      end
    end else if (wr_en && cfg_paddr[1:0] == 2'b00) begin
      case (wr_sel)
        vgsb_pkg::REG_MIN_X: lo_r[0] <= cfg_pwdata[CW-1:0];
        vgsb_pkg::REG_MIN_Y: lo_r[1] <= cfg_pwdata[CW-1:0];
        vgsb_pkg::REG_MIN_Z: lo_r[2] <= cfg_pwdata[CW-1:0];
        vgsb_pkg::REG_MAX_X: hi_r[0] <= cfg_pwdata[CW-1:0];
        vgsb_pkg::REG_MAX_Y: hi_r[1] <= cfg_pwdata[CW-1:0];
        vgsb_pkg::REG_MAX_Z: hi_r[2] <= cfg_pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] rd_val;
  always_comb begin
    case (wr_sel)
      vgsb_pkg::REG_MIN_X: rd_val = lo_r[0];
      vgsb_pkg::REG_MIN_Y: rd_val = lo_r[1];
      vgsb_pkg::REG_MIN_Z: rd_val = lo_r[2];
      vgsb_pkg::REG_MAX_X: rd_val = hi_r[0];
      vgsb_pkg::REG_MAX_Y: rd_val = hi_r[1];
      vgsb_pkg::REG_MAX_Z: rd_val = hi_r[2];
      default:             rd_val = '0;
    endcase
  end
  assign cfg_prdata = {{(32-CW){rd_val[CW-1]}}, rd_val};

  // captured point
  logic [CW-1:0]                 pos_r [3];
  logic [vgsb_pkg::SHARE_W-1:0]  share_r;
  logic                          final_r;
  logic [BW-1:0]                 bin_r [3];
  logic [1:0]                    axis_r;
  logic [3:0]                    st_r;
  logic [IW-1:0]                 ptr_r;
  logic [IW:0]                   vox_r;

  // voxel stores
  logic [vgsb_pkg::CNT_W-1:0] cnt_mem [DEPTH];
  logic [vgsb_pkg::SUM_W-1:0] sum_mem [DEPTH];
  logic [vgsb_pkg::CNT_W-1:0] cnt_q;
  logic [vgsb_pkg::SUM_W-1:0] sum_q;
  logic                       mem_we;
  logic [IW-1:0]              mem_wa, mem_ra;
  logic [vgsb_pkg::CNT_W-1:0] cnt_wd;
  logic [vgsb_pkg::SUM_W-1:0] sum_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= cnt_wd;
      sum_mem[mem_wa] <= sum_wd;
    end
    cnt_q <= cnt_mem[mem_ra];
    sum_q <= sum_mem[mem_ra];
  end

  // axis distance and length, 25-bit signed
  logic signed [CW:0] d_ax, len_ax;
  logic               ax_zero;
  always_comb begin
    d_ax   = $signed({pos_r[axis_r][CW-1], pos_r[axis_r]})
           - $signed({lo_r[axis_r][CW-1], lo_r[axis_r]});
    len_ax = $signed({hi_r[axis_r][CW-1], hi_r[axis_r]})
           - $signed({lo_r[axis_r][CW-1], lo_r[axis_r]});
    ax_zero = (d_ax <= 0) || (len_ax <= 0);
  end

  // shared divider
  vgsb_pkg::div_req_t dreq;
  vgsb_pkg::div_rsp_t drsp;
  vgsb_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '1;
    if (st_r == ST_AXIS && !ax_zero) begin
      dreq.start    = 1'b1;
      // d < 2^25, times GRID-1 fits well within the divider width
      dreq.dividend = DW'(d_ax[CW-1:0]) * DW'(GRID - 1);
      dreq.divisor  = DW'(len_ax[CW-1:0]);
    end else if (st_r == ST_OUTDIV) begin
      dreq.start    = 1'b1;
      dreq.dividend = sum_q;
      dreq.divisor  = DW'(cnt_q);
    end
  end

  logic [IW-1:0] idx_pt;
  assign idx_pt = IW'(bin_r[0]) + IW'(bin_r[1]) * IW'(GRID)
                + IW'(bin_r[2]) * IW'(GRID * GRID);

  logic [vgsb_pkg::SHARE_W-1:0] share_sat;
  assign share_sat = (share_r > vgsb_pkg::SHARE_ONE) ? vgsb_pkg::SHARE_ONE : share_r;

  logic [vgsb_pkg::RATIO_W-1:0] ratio_r;
  logic                         empty_r;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_r;
    mem_ra = idx_pt;
    cnt_wd = '0;
    sum_wd = '0;
    case (st_r)
      ST_CLEAR: mem_we = 1'b1;
      ST_AWAIT, ST_RD: mem_ra = idx_pt;
      ST_WR: begin
        mem_wa = idx_pt;
        mem_we = (cnt_q != vgsb_pkg::COUNT_MAX);
        cnt_wd = cnt_q + 32'd1;
        sum_wd = sum_q + vgsb_pkg::SUM_W'(share_sat);
      end
      ST_OUTRD: mem_ra = vox_r[IW-1:0];
      ST_OUTDIV: begin
        // clear the entry as it is read out
        mem_we = 1'b1;
        mem_wa = vox_r[IW-1:0];
        mem_ra = vox_r[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_CLEAR;
      ptr_r   <= '0;
      axis_r  <= '0;
      vox_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (st_r)
        ST_CLEAR: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r == IW'(DEPTH - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            axis_r <= '0;
            st_r   <= ST_AXIS;
          end
        end
        ST_AXIS: begin
          if (ax_zero) begin
            bin_r[axis_r] <= '0;
            if (axis_r == 2'd2) st_r <= ST_RD;
            else axis_r <= axis_r + 2'd1;
          end else begin
            st_r <= ST_AWAIT;
          end
        end
        ST_AWAIT: begin
          if (drsp.done) begin
            bin_r[axis_r] <= (drsp.quot > DW'(GRID - 1)) ? BW'(GRID - 1)
                                                          : drsp.quot[BW-1:0];
            if (axis_r == 2'd2) st_r <= ST_RD;
            else begin
              axis_r <= axis_r + 2'd1;
              st_r   <= ST_AXIS;
            end
          end
        end
        ST_RD: st_r <= ST_WR;
        ST_WR: begin
          if (final_r) begin
            vox_r <= '0;
            st_r  <= ST_OUTRD;
          end else begin
            st_r <= ST_IDLE;
          end
        end
        ST_OUTRD: st_r <= ST_OUTDIV;
        ST_OUTDIV: begin
          empty_r <= (cnt_q == '0);
          st_r    <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (drsp.done) begin
            ratio_r   <= empty_r ? '0 : drsp.quot[vgsb_pkg::RATIO_W-1:0];
            out_valid <= 1'b1;
            st_r      <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (vox_r == (IW+1)'(TOTAL - 1)) st_r <= ST_IDLE;
            else begin
              vox_r <= vox_r + 1'b1;
              st_r  <= ST_OUTRD;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
    if (st_r == ST_IDLE && in_valid) begin
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
      share_r  <= in_element_share;
      final_r  <= in_final_point;
    end
  end

  assign in_ready        = (st_r == ST_IDLE);
  assign out_voxel_index = vox_r[IW-1:0];
  assign out_voxel_ratio = ratio_r;
  assign out_last_voxel  = (vox_r == (IW+1)'(TOTAL - 1));
endmodule

// ----- verif/tb_voxel_grid_share_binner_unit.sv -----
// tb_voxel_grid_share_binner_unit: self-checking bench for the voxel grid share binner
// depends on vgsb_pkg and the voxel_grid_share_binner_unit rtl
// directed table first, then randomized box settings and point streams with idling
`timescale 1ns / 100ps

module tb_voxel_grid_share_binner_unit;
  localparam int COORD_W = vgsb_pkg::COORD_W;
  localparam int SHARE_W = vgsb_pkg::SHARE_W;
  localparam int CNT_W   = vgsb_pkg::CNT_W;
  localparam int SUM_W   = vgsb_pkg::SUM_W;
  localparam int RATIO_W = vgsb_pkg::RATIO_W;
  localparam int IDX_W   = vgsb_pkg::IDX_W;
  localparam logic [SHARE_W-1:0] SHARE_ONE = vgsb_pkg::SHARE_ONE;
  localparam logic [CNT_W-1:0]   COUNT_MAX = vgsb_pkg::COUNT_MAX;
  localparam logic [2:0] REG_MIN_X = vgsb_pkg::REG_MIN_X;
  localparam logic [2:0] REG_MIN_Y = vgsb_pkg::REG_MIN_Y;
  localparam logic [2:0] REG_MIN_Z = vgsb_pkg::REG_MIN_Z;
  localparam logic [2:0] REG_MAX_X = vgsb_pkg::REG_MAX_X;
  localparam logic [2:0] REG_MAX_Y = vgsb_pkg::REG_MAX_Y;
  localparam logic [2:0] REG_MAX_Z = vgsb_pkg::REG_MAX_Z;

  localparam int GRID      = vgsb_pkg::GRID_DEF;
  localparam int N_VOXELS  = GRID * GRID * GRID;
  localparam int SETTLE    = 400;        // covers one point in flight plus margin
  localparam int LIMIT     = 4_000_000;  // cycles before the run is declared hung
  localparam int HOLD_LONG = 3000;

  // decodes that the block must ignore
  localparam logic [2:0] REG_NONE_LO = 3'd6;
  localparam logic [2:0] REG_NONE_HI = 3'd7;

  localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

  typedef enum logic {ROW_POINT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [2:0]                  sel;
    logic signed [COORD_W-1:0]   x, y, z;   // cfg rows carry the value in x
    logic [SHARE_W-1:0]          share;
    bit                          fin;
    bit                          chk;
    int                          chk_idx;
    int                          chk_ratio;
  } stim_row_t;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic [RATIO_W-1:0] ratio;
    logic               last;
  } voxel_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [SHARE_W-1:0] in_element_share = '0;
  logic in_final_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_voxel_index;
  logic [RATIO_W-1:0] out_voxel_ratio;
  logic out_last_voxel;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  voxel_grid_share_binner_unit #(.GRID(GRID)) dut (.*);

  // shadow state of the block
  logic signed [COORD_W-1:0] box_lo [3];
  logic signed [COORD_W-1:0] box_hi [3];
  logic [CNT_W-1:0] point_cnt [N_VOXELS];
  logic [SUM_W-1:0] share_sum [N_VOXELS];

  voxel_beat_t pending_voxels [$];

  int errors = 0;
  int points_sent = 0;
  int readouts = 0;
  int beats_seen = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_trig = 1'b0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d voxels outstanding", $time, cycles,
               pending_voxels.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off requested by the stimulus
  always @(posedge clk) begin
    if (hold_trig) begin
      hold_left = HOLD_LONG;
      hold_trig = 1'b0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // compare every accepted voxel beat with the oldest prediction
  always @(posedge clk) begin
    voxel_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (pending_voxels.size() == 0) begin
        errors++;
        $display("%0t unexpected voxel beat idx=%0d ratio=%0d last=%0b", $time,
                 out_voxel_index, out_voxel_ratio, out_last_voxel);
      end else begin
        want = pending_voxels.pop_front();
        if (out_voxel_index !== want.idx) begin
          errors++;
          $display("%0t voxel_index expected %0d got %0d", $time, want.idx, out_voxel_index);
        end
        if (out_voxel_ratio !== want.ratio) begin
          errors++;
          $display("%0t voxel_ratio (idx %0d) expected %0d got %0d", $time, want.idx,
                   want.ratio, out_voxel_ratio);
        end
        if (out_last_voxel !== want.last) begin
          errors++;
          $display("%0t last_voxel (idx %0d) expected %0b got %0b", $time, want.idx,
                   want.last, out_last_voxel);
        end
      end
    end
  end

  // bin one axis: floor((c-lo)*(GRID-1)/(hi-lo)), zero for empty axis or below box
  function automatic int unsigned axis_bin(logic signed [COORD_W-1:0] c,
                                           logic signed [COORD_W-1:0] lo,
                                           logic signed [COORD_W-1:0] hi);
    longint d, span, q;
    d    = longint'(c) - longint'(lo);
    span = longint'(hi) - longint'(lo);
    if (span <= 0 || d <= 0) return 0;
    q = (d * (GRID - 1)) / span;
    if (q > GRID - 1) q = GRID - 1;
    return 32'(q);
  endfunction

  task automatic clear_voxels();
    for (int k = 0; k < N_VOXELS; k++) begin
      point_cnt[k] = '0;
      share_sum[k] = '0;
    end
  endtask

  task automatic shadow_cfg(logic [2:0] sel, logic [31:0] val);
    case (sel)
      REG_MIN_X: box_lo[0] = val[COORD_W-1:0];
      REG_MIN_Y: box_lo[1] = val[COORD_W-1:0];
      REG_MIN_Z: box_lo[2] = val[COORD_W-1:0];
      REG_MAX_X: box_hi[0] = val[COORD_W-1:0];
      REG_MAX_Y: box_hi[1] = val[COORD_W-1:0];
      REG_MAX_Z: box_hi[2] = val[COORD_W-1:0];
      default: ;  // unmapped decode, ignored
    endcase
  endtask

  // accumulate one accepted point; a final point queues the whole readout
  task automatic bin_point(logic signed [COORD_W-1:0] x, y, z,
                           logic [SHARE_W-1:0] share, bit fin);
    int unsigned v;
    logic [SHARE_W-1:0] sh;
    voxel_beat_t b;
    v  = axis_bin(x, box_lo[0], box_hi[0]) + axis_bin(y, box_lo[1], box_hi[1]) * GRID
       + axis_bin(z, box_lo[2], box_hi[2]) * GRID * GRID;
    sh = (share > SHARE_ONE) ? SHARE_ONE : share;
    // full voxel count: the point is dropped
    if (point_cnt[v] != COUNT_MAX) begin
      point_cnt[v] = point_cnt[v] + 32'd1;
      share_sum[v] = share_sum[v] + SUM_W'(sh);
    end
    points_sent++;
    if (fin) begin
      readouts++;
      for (int k = 0; k < N_VOXELS; k++) begin
        b.idx   = k[IDX_W-1:0];
        b.ratio = (point_cnt[k] == 0) ? '0
                : RATIO_W'(share_sum[k] / SUM_W'(point_cnt[k]));
        b.last  = (k == N_VOXELS - 1);
        pending_voxels = {pending_voxels, b};
      end
      clear_voxels();
    end
  endtask

  // offer one point beat, optionally after an idle gap, and wait for acceptance
  task automatic send_point(logic signed [COORD_W-1:0] x, y, z,
                            logic [SHARE_W-1:0] share, bit fin);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_pos_x         <= x;
    in_pos_y         <= y;
    in_pos_z         <= z;
    in_element_share <= share;
    in_final_point   <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bin_point(x, y, z, share, fin);
  endtask

  // park the input, wait for every predicted voxel, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_voxels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // setup + access; the register lands at the access edge since pready is tied high
  task automatic cfg_write(logic [2:0] sel, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    shadow_cfg(sel, val);
    @(posedge clk);
  endtask

  // coordinate mostly in or near the box, sometimes anywhere in the field
  function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] lo,
                                                            logic signed [COORD_W-1:0] hi);
    longint span, v;
    span = longint'(hi) - longint'(lo);
    if ($urandom_range(0, 9) < 2 || span <= 0) return COORD_W'($urandom);
    v = longint'(lo) + longint'($urandom_range(0, 32'(span + span / 8))) - span / 16;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [SHARE_W-1:0] pick_share();
    case ($urandom_range(0, 7))
      0:       return SHARE_W'($urandom_range(0, 2 ** SHARE_W - 1));  // includes over-range
      1:       return SHARE_ONE;
      2:       return '0;
      default: return SHARE_W'($urandom_range(0, SHARE_ONE));
    endcase
  endfunction

  // directed rows: extremes, saturation, averaging, inverted / empty axes, unmapped decodes
  stim_row_t directed [16] = '{
    '{ROW_POINT, 3'd0, 24'sd0, 24'sd0, 24'sd0, 17'd65536, 1, 1, 0, 65536},
    '{ROW_POINT, 3'd0, C_MAX, C_MAX, C_MAX, 17'd131071, 1, 1, 63, 65536},
    '{ROW_POINT, 3'd0, C_MIN, C_MIN, C_MIN, 17'd0, 1, 1, 0, 0},
    '{ROW_POINT, 3'd0, 24'sd65536, 24'sd0, 24'sd0, 17'd65536, 0, 0, 0, 0},
    '{ROW_POINT, 3'd0, 24'sd65536, 24'sd0, 24'sd0, 17'd0, 1, 1, 3, 32768},
    '{ROW_POINT, 3'd0, 24'sd32768, 24'sd32768, 24'sd32768, 17'd1, 1, 1, 21, 1},
    '{ROW_POINT, 3'd0, -24'sd1, 24'sd65535, 24'sd21845, 17'd70000, 0, 0, 0, 0},
    '{ROW_POINT, 3'd0, 24'sd21846, 24'sd43690, 24'sd65536, 17'd12345, 1, 0, 0, 0},
    '{ROW_CFG, REG_MIN_X, 24'sd65536, 24'sd0, 24'sd0, 17'd0, 0, 0, 0, 0},
    '{ROW_CFG, REG_MAX_X, 24'sd0, 24'sd0, 24'sd0, 17'd0, 0, 0, 0, 0},
    '{ROW_CFG, REG_MAX_Y, 24'sd0, 24'sd0, 24'sd0, 17'd0, 0, 0, 0, 0},
    '{ROW_POINT, 3'd0, C_MAX, C_MAX, 24'sd0, 17'd100, 1, 1, 0, 100},
    '{ROW_CFG, REG_NONE_LO, 24'sd123, 24'sd0, 24'sd0, 17'd0, 0, 0, 0, 0},
    '{ROW_CFG, REG_NONE_HI, 24'sd456, 24'sd0, 24'sd0, 17'd0, 0, 0, 0, 0},
    '{ROW_POINT, 3'd0, 24'sd65536, 24'sd65536, 24'sd65536, 17'd65536, 0, 0, 0, 0},
    '{ROW_POINT, 3'd0, 24'sd4000, 24'sd70000, 24'sd65536, 17'd4321, 1, 0, 0, 0}
  };

  initial begin
    logic signed [COORD_W-1:0] lo, hi;
    longint span;
    int n_items;
    bit fin;

    box_lo = '{default: '0};
    box_hi = '{default: 24'sd65536};
    clear_voxels();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; cfg rows wait for the block to go idle first
    foreach (directed[r]) begin
      if (directed[r].kind == ROW_CFG) begin
        drain();
        cfg_write(directed[r].sel, 32'(directed[r].x));
      end else begin
        send_point(directed[r].x, directed[r].y, directed[r].z, directed[r].share,
                   directed[r].fin);
        if (directed[r].chk &&
            pending_voxels[pending_voxels.size() - N_VOXELS + directed[r].chk_idx].ratio
              !== RATIO_W'(directed[r].chk_ratio)) begin
          errors++;
          $display("%0t row %0d: voxel %0d expected ratio %0d predicted %0d", $time, r,
                   directed[r].chk_idx, directed[r].chk_ratio,
                   pending_voxels[pending_voxels.size() - N_VOXELS + directed[r].chk_idx].ratio);
        end
      end
    end

    // random phases: quiet, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int a = 0; a < 3; a++) begin
        case (ph)
          0: begin lo = C_MIN; hi = C_MAX; end  // widest box
          2: begin lo = COORD_W'($urandom); hi = COORD_W'($urandom); end  // may be inverted
          default: begin
            lo   = COORD_W'($urandom_range(0, 2 ** 23) - 2 ** 22);
            span = $urandom_range(1, 2 ** 20);
            hi   = COORD_W'(lo + span);
          end
        endcase
        cfg_write(3'(a), 32'(lo));
        cfg_write(3'(a + 3), 32'(hi));
      end
      // receiver holds off while the sender keeps pushing, so the block backs up
      if (ph == 0) hold_trig = 1'b1;
      n_items = 48;
      for (int i = 0; i < n_items; i++) begin
        fin = ($urandom_range(0, 7) == 0) || (i == n_items - 1);
        send_point(pick_coord(box_lo[0], box_hi[0]), pick_coord(box_lo[1], box_hi[1]),
                   pick_coord(box_lo[2], box_hi[2]), pick_share(), fin);
        // sender pause until everything has come back
        if (ph == 1 && i == n_items / 2) drain();
      end
    end

    drain();
    $display("covered %0d points and %0d readouts (%0d voxel beats) over 4 idling phases",
             points_sent, readouts, beats_seen);
    $display("box settings: default, inverted/empty axes, full range, random and narrow");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
